// File: rtl/ulpc_pkg.sv
package ulpc_pkg;

  // status codes, also used as the latched first error (ok means none)
  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_EMPTY   = 4'd1,
    ST_CTRL    = 4'd2,
    ST_QUOTE   = 4'd3,
    ST_DOTS    = 4'd4,
    ST_DOT     = 4'd5,
    ST_SPECIAL = 4'd6,
    ST_UTF8    = 4'd7,
    ST_OPEN    = 4'd8
  } ulpc_status_e;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 4;
  localparam int unsigned CpW     = 21;

  // ascii characters with a rule of their own
  localparam logic [7:0] ChDel       = 8'h7f;
  localparam logic [7:0] ChSpaceMin  = 8'h20;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChDot       = 8'h2e;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChAt        = 8'h40;
  localparam logic [7:0] ChHash      = 8'h23;

  // utf-8 lead byte bounds
  localparam logic [7:0] LeadMin2 = 8'hc2;
  localparam logic [7:0] LeadMin3 = 8'he0;
  localparam logic [7:0] LeadMin4 = 8'hf0;
  localparam logic [7:0] LeadEnd  = 8'hf5;

  // code point bounds for overlong, surrogate and range checks
  localparam logic [CpW-1:0] CpMin2    = 21'h000080;
  localparam logic [CpW-1:0] CpMin3    = 21'h000800;
  localparam logic [CpW-1:0] CpMin4    = 21'h010000;
  localparam logic [CpW-1:0] CpMax     = 21'h10ffff;
  localparam logic [CpW-1:0] CpSurrLo  = 21'h00d800;
  localparam logic [CpW-1:0] CpSurrHi  = 21'h00dfff;

  // per-string checker state
  typedef struct packed {
    logic               inside_quote;
    logic               escape_pending;
    logic               seen_any_char;
    logic               previous_was_dot;
    logic [1:0]         continuation_left;
    logic [1:0]         sequence_length;
    logic [CpW-1:0]     code_point_acc;
    ulpc_status_e       first_error;
  } ulpc_state_t;

  // beat held in the input register
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
    logic             end_without_byte;
  } ulpc_beat_t;

endpackage

// File: rtl/utf8_email_local_part_check_top.sv
// Checks an email local part, one byte per beat, as strict UTF-8 under the
// RFC 6531 local-part rules, and gives one status beat when the string ends
// (at a beat with tlast, or a beat with tuser set, which ends it without a
// byte). A byte is taken every cycle, but a waiting status stalls input only
// when the next beat also closes a string. The status is registered as the
// closing beat leaves the input register. The per-string state is updated
// from the input register, so each string is checked back to back with no
// gap. The first error is latched; later bytes are ignored until the end.
// cfg_wdata_i set to 1 also bars # ^ ` { } | ~ outside quotes; write it only
// while no string is in progress.
module utf8_email_local_part_check_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  input  logic       s_axis_tuser,   // [0] end_without_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [3:0] status, [7:4] zero
);

  logic                   extra_en_q;
  logic                   in_valid_q;
  ulpc_pkg::ulpc_beat_t   beat_q;
  ulpc_pkg::ulpc_state_t  state_q;
  ulpc_pkg::ulpc_state_t  state_d;
  ulpc_pkg::ulpc_status_e status;
  logic                   emit;
  logic                   out_free;
  logic                   advance;
  logic                   in_accept;

  // held beat moves on unless its status has nowhere to go
  assign advance       = in_valid_q && (!emit || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      extra_en_q <= cfg_wdata_i;
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      beat_q.data_byte        <= s_axis_tdata;
      beat_q.last_byte        <= s_axis_tlast;
      beat_q.end_without_byte <= s_axis_tuser;
    end
  end

  // per-string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  ulpc_step u_step (
    .state_i                 (state_q),
    .beat_i                  (beat_q),
    .extra_specials_enable_i (extra_en_q),
    .state_next_o            (state_d),
    .emit_o                  (emit),
    .status_o                (status)
  );

  ulpc_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance && emit),
    .status_i      (status),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: rtl/ulpc_step.sv
module ulpc_step (
  input  ulpc_pkg::ulpc_state_t  state_i,
  input  ulpc_pkg::ulpc_beat_t   beat_i,
  input  logic                   extra_specials_enable_i,
  output ulpc_pkg::ulpc_state_t  state_next_o,
  output logic                   emit_o,
  output ulpc_pkg::ulpc_status_e status_o
);

  ulpc_pkg::ulpc_state_t  nxt;
  ulpc_pkg::ulpc_status_e err;
  ulpc_pkg::ulpc_status_e fin;
  logic [7:0]             b;
  logic [ulpc_pkg::CpW-1:0] acc_new;
  logic [1:0]             cont_new;

  assign b = beat_i.data_byte;

  // byte checks and next state
  always_comb begin
    nxt      = state_i;
    err      = ulpc_pkg::ST_OK;
    acc_new  = {state_i.code_point_acc[ulpc_pkg::CpW-7:0], b[5:0]};
    cont_new = state_i.continuation_left - 2'd1;
    emit_o   = 1'b1;

    if (!beat_i.end_without_byte) begin
      emit_o = beat_i.last_byte;
      if (state_i.first_error == ulpc_pkg::ST_OK) begin
        if (state_i.continuation_left == 2'd0) begin
          if (!b[7]) begin
            // ascii character
            if (b < ulpc_pkg::ChSpaceMin || b == ulpc_pkg::ChDel) begin
              err = ulpc_pkg::ST_CTRL;
            end else if (!state_i.inside_quote) begin
              case (b) inside
                ulpc_pkg::ChQuote: begin
                  if (!state_i.seen_any_char || state_i.previous_was_dot) begin
                    nxt.inside_quote = 1'b1;
                  end else begin
                    err = ulpc_pkg::ST_QUOTE;
                  end
                end
                ulpc_pkg::ChDot: begin
                  if (state_i.seen_any_char && state_i.previous_was_dot) begin
                    err = ulpc_pkg::ST_DOTS;
                  end else if (!state_i.seen_any_char || beat_i.last_byte) begin
                    err = ulpc_pkg::ST_DOT;
                  end
                end
                8'h28, 8'h29, 8'h3c, 8'h3e, ulpc_pkg::ChAt, 8'h2c, 8'h3b, 8'h3a,
                ulpc_pkg::ChBackslash, 8'h5b, 8'h5d, 8'h20: begin
                  err = ulpc_pkg::ST_SPECIAL;
                end
                ulpc_pkg::ChHash, 8'h5e, 8'h60, 8'h7e, 8'h7b, 8'h7d, 8'h7c: begin
                  if (extra_specials_enable_i) begin
                    err = ulpc_pkg::ST_SPECIAL;
                  end
                end
                default: ;
              endcase
            end else if (state_i.escape_pending) begin
              nxt.escape_pending = 1'b0;
            end else if (b == ulpc_pkg::ChQuote) begin
              nxt.inside_quote = 1'b0;
            end else if (b == ulpc_pkg::ChBackslash) begin
              nxt.escape_pending = 1'b1;
            end
            if (err == ulpc_pkg::ST_OK) begin
              nxt.previous_was_dot = (b == ulpc_pkg::ChDot);
              nxt.seen_any_char    = 1'b1;
            end
          end else if (b < ulpc_pkg::LeadMin2 || b >= ulpc_pkg::LeadEnd) begin
            err = ulpc_pkg::ST_UTF8;
          end else if (b < ulpc_pkg::LeadMin3) begin
            nxt.code_point_acc    = {16'd0, b[4:0]};
            nxt.sequence_length   = 2'd1;
            nxt.continuation_left = 2'd1;
          end else if (b < ulpc_pkg::LeadMin4) begin
            nxt.code_point_acc    = {17'd0, b[3:0]};
            nxt.sequence_length   = 2'd2;
            nxt.continuation_left = 2'd2;
          end else begin
            nxt.code_point_acc    = {18'd0, b[2:0]};
            nxt.sequence_length   = 2'd3;
            nxt.continuation_left = 2'd3;
          end
        end else if (b[7:6] != 2'b10) begin
          err = ulpc_pkg::ST_UTF8;
        end else begin
          // continuation byte
          nxt.code_point_acc    = acc_new;
          nxt.continuation_left = cont_new;
          if (cont_new == 2'd0) begin
            if (state_i.sequence_length == 2'd1) begin
              if (acc_new < ulpc_pkg::CpMin2) err = ulpc_pkg::ST_UTF8;
            end else if (state_i.sequence_length == 2'd2) begin
              if (acc_new < ulpc_pkg::CpMin3 ||
                  (acc_new >= ulpc_pkg::CpSurrLo && acc_new <= ulpc_pkg::CpSurrHi)) begin
                err = ulpc_pkg::ST_UTF8;
              end
            end else begin
              if (acc_new < ulpc_pkg::CpMin4 || acc_new > ulpc_pkg::CpMax) begin
                err = ulpc_pkg::ST_UTF8;
              end
            end
            if (err == ulpc_pkg::ST_OK) begin
              nxt.previous_was_dot = 1'b0;
              nxt.seen_any_char    = 1'b1;
            end
          end
        end
        nxt.first_error = err;
      end
    end

    // end-of-string status
    if (nxt.first_error != ulpc_pkg::ST_OK) begin
      fin = nxt.first_error;
    end else if (nxt.continuation_left != 2'd0) begin
      fin = ulpc_pkg::ST_UTF8;
    end else if (!nxt.seen_any_char) begin
      fin = ulpc_pkg::ST_EMPTY;
    end else if (beat_i.end_without_byte && !nxt.inside_quote && nxt.previous_was_dot) begin
      fin = ulpc_pkg::ST_DOT;
    end else if (nxt.inside_quote) begin
      fin = ulpc_pkg::ST_OPEN;
    end else begin
      fin = ulpc_pkg::ST_OK;
    end

    // string closed: back to the reset state
    if (emit_o) begin
      nxt = '0;
    end
  end

  assign state_next_o = nxt;
  assign status_o     = fin;

endmodule

// File: rtl/ulpc_out_reg.sv
module ulpc_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  ulpc_pkg::ulpc_status_e status_i,
  output logic                   free_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata
);

  logic                   valid_q;
  ulpc_pkg::ulpc_status_e status_q;

  // register may be loaded when empty or drained this cycle
  assign free_o = !valid_q || m_axis_tready;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // status payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= status_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(8 - ulpc_pkg::StatusW){1'b0}}, status_q};

endmodule
